@@ hdl/rtt_predictive_cwnd_update_assert.svh @@
// Assertion macros shared by the window controller RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef RTT_PREDICTIVE_CWND_UPDATE_ASSERT_SVH
`define RTT_PREDICTIVE_CWND_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpc: next-cycle check failed");

// Expression must hold at every clock edge out of reset.
`define RPC_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rpc: invariant failed");

`endif

@@ hdl/rpc_pkg.sv @@
`timescale 1ns / 1ps
package rpc_pkg;

	// Field widths
	localparam int SegW  = 16;
	localparam int RttW  = 24;
	localparam int ByteW = 32;

	// Datapath widths
	localparam int NumW  = 2 * ByteW;       // dividend and accumulator
	localparam int DenW  = RttW + 3;        // holds 6 * RTT
	localparam int ProdW = ByteW + DenW;    // 32 x 27 product
	localparam int LpW   = ByteW + 1;       // predicted load in segments
	localparam int WnW   = ByteW + RttW + 2; // new window in segments
	localparam int DiffW = LpW + 2;         // signed Lpred - L1

	// Divider retires two quotient bits per cycle
	localparam int DivItW = 6;
	localparam logic [DivItW-1:0] DivItShort = DivItW'(ByteW / 2);
	localparam logic [DivItW-1:0] DivItLong  = DivItW'(NumW / 2);

	// Lower bound of predicted load and window, in segments
	localparam int MinSegs = 2;

	// Segment size after reset
	localparam logic [SegW-1:0] SegReset = SegW'(1460);

	// Microprogram
	localparam int StepW = 5;

	typedef enum logic [1:0] {
		MODE_RTT    = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_THRESH = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {MA_NONE, MA_L1, MA_W1, MA_DABS, MA_WN} mul_a_t;
	typedef enum logic [2:0] {MB_M6, MB_R5, MB_R, MB_M, MB_SEG} mul_b_t;
	typedef enum logic [2:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADDSUB_D, ACC_CLAMP
	} acc_op_t;
	typedef enum logic [2:0] {DIV_NONE, DIV_L1, DIV_W1, DIV_LP, DIV_WN} div_op_t;
	typedef enum logic [2:0] {LD_NONE, LD_L1, LD_W1, LD_LP, LD_WN} ld_t;
	typedef enum logic [1:0] {C_NEXT, C_NOT_UPD, C_DIV_BUSY} cond_t;
	typedef enum logic [1:0] {FIN_NONE, FIN_PLAIN, FIN_UPD} fin_t;

	typedef struct packed {
		mul_a_t           mul_a;
		mul_b_t           mul_b;
		acc_op_t          acc_op;
		div_op_t          div_op;
		ld_t              ld;
		cond_t            cond;
		logic [StepW-1:0] target;
		fin_t             fin;
	} ctl_t;

	typedef struct packed {
		logic not_upd;
		logic div_busy;
	} status_t;

	localparam ctl_t CtlIdle = '{
		mul_a:  MA_NONE,
		mul_b:  MB_M6,
		acc_op: ACC_HOLD,
		div_op: DIV_NONE,
		ld:     LD_NONE,
		cond:   C_NEXT,
		target: '0,
		fin:    FIN_NONE
	};

	// Jump targets
	localparam logic [StepW-1:0] StepWaitL1 = StepW'(2);
	localparam logic [StepW-1:0] StepWaitW1 = StepW'(4);
	localparam logic [StepW-1:0] StepWaitLp = StepW'(11);
	localparam logic [StepW-1:0] StepWaitWn = StepW'(18);
	localparam logic [StepW-1:0] StepPlain  = StepW'(22);

	// Control store: window update program, plain finish at the end
	function automatic ctl_t ucode(input logic [StepW-1:0] step);
		ctl_t c;
		c = CtlIdle;
		case (step)
			5'd0: begin
				c.cond = C_NOT_UPD;
				c.target = StepPlain;
			end
			5'd1: c.div_op = DIV_L1;
			5'd2: begin
				c.cond = C_DIV_BUSY;
				c.target = StepWaitL1;
			end
			5'd3: begin
				c.ld = LD_L1;
				c.div_op = DIV_W1;
			end
			5'd4: begin
				c.cond = C_DIV_BUSY;
				c.target = StepWaitW1;
			end
			5'd5: begin
				c.ld = LD_W1;
				c.mul_a = MA_L1;
				c.mul_b = MB_M6;
			end
			5'd6: begin
				c.mul_a = MA_W1;
				c.mul_b = MB_M6;
				c.acc_op = ACC_LOAD;
			end
			5'd7: begin
				c.mul_a = MA_W1;
				c.mul_b = MB_R5;
				c.acc_op = ACC_ADD;
			end
			5'd8: c.acc_op = ACC_SUB;
			5'd9: c.acc_op = ACC_CLAMP;
			5'd10: c.div_op = DIV_LP;
			5'd11: begin
				c.cond = C_DIV_BUSY;
				c.target = StepWaitLp;
			end
			5'd12: c.ld = LD_LP;
			5'd13: begin
				c.mul_a = MA_W1;
				c.mul_b = MB_R;
			end
			5'd14: begin
				c.mul_a = MA_DABS;
				c.mul_b = MB_M;
				c.acc_op = ACC_LOAD;
			end
			5'd15: c.acc_op = ACC_ADDSUB_D;
			5'd16: c.acc_op = ACC_CLAMP;
			5'd17: c.div_op = DIV_WN;
			5'd18: begin
				c.cond = C_DIV_BUSY;
				c.target = StepWaitWn;
			end
			5'd19: c.ld = LD_WN;
			5'd20: begin
				c.mul_a = MA_WN;
				c.mul_b = MB_SEG;
			end
			5'd21: c.fin = FIN_UPD;
			default: c.fin = FIN_PLAIN;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/rpc_div.sv @@
`timescale 1ns / 1ps
module rpc_div import rpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NumW-1:0]   num,
	input  logic [DenW-1:0]   den,
	input  logic [DivItW-1:0] iters,
	output logic              busy,
	output logic [NumW-1:0]   quot
);

	logic [NumW-1:0]   q_q;
	logic [DenW-1:0]   rem_q;
	logic [DenW-1:0]   den_q;
	logic [DivItW-1:0] cnt_q;

	logic [NumW-1:0] q_nx;
	logic [DenW-1:0] rem_nx;
	logic [DenW:0]   trial;

	assign busy = (cnt_q != '0);
	assign quot = q_q;

	// Two restoring steps per cycle
	always_comb begin
		q_nx = q_q;
		rem_nx = rem_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_nx, q_nx[NumW-1]};
			q_nx = {q_nx[NumW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial = trial - {1'b0, den_q};
				q_nx[0] = 1'b1;
			end
			rem_nx = trial[DenW-1:0];
		end
	end

	// Count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= iters;
		end else if (busy) begin
			cnt_q <= cnt_q - DivItW'(1);
		end
	end

	// Load operands, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			q_q <= q_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

@@ hdl/rpc_dp.sv @@
`timescale 1ns / 1ps
module rpc_dp import rpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [ByteW-1:0] inflight,
	input  logic [ByteW-1:0] cwnd,
	input  logic [RttW-1:0]  rtt,
	input  logic [RttW-1:0]  min_rtt,
	input  logic [SegW-1:0]  seg,
	output logic             div_busy,
	output logic [ByteW-1:0] new_window
);

	logic [ByteW-1:0] l1_q;
	logic [ByteW-1:0] w1_q;
	logic [LpW-1:0]   lp_q;
	logic [WnW-1:0]   wn_q;
	logic [ProdW-1:0] prod_q;
	logic signed [NumW-1:0] acc_q;

	logic [DenW-1:0]  m6;
	logic [DenW-1:0]  r5;
	logic [ByteW-1:0] mul_a_v;
	logic [DenW-1:0]  mul_b_v;
	logic [ProdW-1:0] mul_p;
	logic signed [NumW-1:0] prod_ext;

	logic [DiffW-1:0] d_pos;
	logic [DiffW-1:0] d_mag;
	logic             d_neg;
	logic [ByteW-1:0] d_abs;

	logic              div_start;
	logic [NumW-1:0]   div_num;
	logic [DenW-1:0]   div_den;
	logic [DivItW-1:0] div_iters;
	logic [NumW-1:0]   quot;

	logic [LpW-1:0] lp_v;
	logic [WnW-1:0] wn_v;
	logic [WnW-1:0] wn_cl;

	// Scaled RTT operands
	assign m6 = DenW'({min_rtt, 2'b00}) + DenW'({min_rtt, 1'b0});
	assign r5 = DenW'({rtt, 2'b00}) + DenW'(rtt);

	// Signed Lpred - L1 as sign and magnitude
	assign d_pos = DiffW'(lp_q) - DiffW'(l1_q);
	assign d_mag = DiffW'(l1_q) - DiffW'(lp_q);
	assign d_neg = d_pos[DiffW-1];
	assign d_abs = d_neg ? d_mag[ByteW-1:0] : d_pos[ByteW-1:0];

	// Select multiplier operands
	always_comb begin
		case (ctl.mul_a)
			MA_L1:   mul_a_v = l1_q;
			MA_W1:   mul_a_v = w1_q;
			MA_DABS: mul_a_v = d_abs;
			MA_WN:   mul_a_v = wn_q[ByteW-1:0];
			default: mul_a_v = '0;
		endcase
		case (ctl.mul_b)
			MB_M6:   mul_b_v = m6;
			MB_R5:   mul_b_v = r5;
			MB_R:    mul_b_v = DenW'(rtt);
			MB_M:    mul_b_v = DenW'(min_rtt);
			MB_SEG:  mul_b_v = DenW'(seg);
			default: mul_b_v = '0;
		endcase
	end

	assign mul_p = mul_a_v * mul_b_v;
	assign prod_ext = signed'(NumW'(prod_q));

	// Select divider operands
	always_comb begin
		div_start = (ctl.div_op != DIV_NONE);
		case (ctl.div_op)
			DIV_L1: begin
				div_num = {inflight, {ByteW{1'b0}}};
				div_den = DenW'(seg);
				div_iters = DivItShort;
			end
			DIV_W1: begin
				div_num = {cwnd, {ByteW{1'b0}}};
				div_den = DenW'(seg);
				div_iters = DivItShort;
			end
			DIV_LP: begin
				div_num = unsigned'(acc_q);
				div_den = m6;
				div_iters = DivItLong;
			end
			DIV_WN: begin
				div_num = unsigned'(acc_q);
				div_den = DenW'(rtt);
				div_iters = DivItLong;
			end
			default: begin
				div_num = '0;
				div_den = '0;
				div_iters = DivItShort;
			end
		endcase
	end

	rpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.iters  (div_iters),
		.busy   (div_busy),
		.quot   (quot)
	);

	// Clamp quotients to the two-segment floor; bump an unchanged window
	assign lp_v = quot[LpW-1:0];
	assign wn_v = quot[WnW-1:0];
	assign wn_cl = (wn_v < WnW'(MinSegs)) ? WnW'(MinSegs) : wn_v;

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctl.mul_a != MA_NONE) begin
			prod_q <= mul_p;
		end
		case (ctl.acc_op)
			ACC_LOAD:     acc_q <= prod_ext;
			ACC_ADD:      acc_q <= acc_q + prod_ext;
			ACC_SUB:      acc_q <= acc_q - prod_ext;
			ACC_ADDSUB_D: acc_q <= d_neg ? (acc_q - prod_ext) : (acc_q + prod_ext);
			ACC_CLAMP:    acc_q <= acc_q[NumW-1] ? '0 : acc_q;
			default:      acc_q <= acc_q;
		endcase
		case (ctl.ld)
			LD_L1: l1_q <= quot[ByteW-1:0];
			LD_W1: w1_q <= quot[ByteW-1:0];
			LD_LP: lp_q <= (lp_v < LpW'(MinSegs)) ? LpW'(MinSegs) : lp_v;
			LD_WN: wn_q <= (wn_cl == WnW'(w1_q)) ? (wn_cl + WnW'(1)) : wn_cl;
			default: ;
		endcase
	end

	// Window in bytes, saturated
	assign new_window = ((|wn_q[WnW-1:ByteW]) || (|prod_q[ProdW-1:ByteW])) ?
		'1 : prod_q[ByteW-1:0];

endmodule

@@ hdl/rpc_seq.sv @@
`timescale 1ns / 1ps
module rpc_seq import rpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t st,
	input  logic    fin_ok,
	output ctl_t    ctl,
	output logic    busy
);

	logic [StepW-1:0] step_q;
	logic             busy_q;

	assign busy = busy_q;
	assign ctl = busy_q ? ucode(step_q) : CtlIdle;

	// Advance the step counter, take jumps, stop on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (ctl.fin != FIN_NONE) begin
				if (fin_ok) begin
					busy_q <= 1'b0;
				end
			end else begin
				case (ctl.cond)
					C_NOT_UPD:  step_q <= st.not_upd ? ctl.target : step_q + StepW'(1);
					C_DIV_BUSY: step_q <= st.div_busy ? ctl.target : step_q + StepW'(1);
					default:    step_q <= step_q + StepW'(1);
				endcase
			end
		end
	end

endmodule

@@ hdl/rtt_predictive_cwnd_update.sv @@
`timescale 1ns / 1ps
// RTT-predictive congestion window controller.
// Input channel s_axis: tuser carries the mode (0 RTT sample, 1 window update,
// 2 threshold query, 3 no action); tdata carries the ACK-event fields.
// Output channel m_axis: one result per input transfer, tuser = window_changed,
// tdata = new window and new threshold in bytes.
// cfg_wr_en/cfg_wr_data write the segment size; write it only while idle.
// Steps: an RTT sample, a threshold query or a skipped update jumps from the
// first step straight to the plain finish. A window update runs the full
// microprogram: four divisions in the shared two-bit-per-cycle divider (two
// short and two long), a wait step per division that holds until it finishes,
// and 18 control steps.
// Flow: one item is in work at a time; the next transfer is taken once the
// result is registered. s_axis_tready is high whenever the sequencer is idle,
// also while a finished result still waits in the output register. If
// m_axis_tready is low while a result waits there, the sequencer holds at its
// finish step until the output register frees up, and s_axis_tready stays low
// meanwhile.
// Reset: minimum RTT goes to all ones, round end to zero, segment size to
// 1460 bytes, and both channels come up empty.
`include "rtt_predictive_cwnd_update_assert.svh"
module rtt_predictive_cwnd_update import rpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,   // segment_bytes
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// s_axis_tdata from bit 0: rtt_sample_us[24], acked_seq[32], next_send_seq[32],
	// inflight_bytes[32], window_bytes[32], latest_rtt_us[24], threshold_bytes[32]
	input  logic [207:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // new_window_bytes[32], new_threshold_bytes[32]
	output logic         m_axis_tuser   // window_changed
);

	logic [SegW-1:0] seg_q;
	logic [RttW-1:0] least_q;
	logic [ByteW-1:0] round_end_q;

	mode_t            mode_q;
	logic [RttW-1:0]  sample_q;
	logic [ByteW-1:0] acked_q;
	logic [ByteW-1:0] next_q;
	logic [ByteW-1:0] inflight_q;
	logic [ByteW-1:0] cwnd_q;
	logic [RttW-1:0]  latest_q;
	logic [ByteW-1:0] thresh_q;

	logic             out_valid_q;
	logic             out_changed_q;
	logic [ByteW-1:0] out_window_q;
	logic [ByteW-1:0] out_thresh_q;

	logic             in_fire;
	logic             seq_busy;
	logic             fin_ok;
	logic             fire;
	ctl_t             ctl;
	status_t          st;
	logic [SegW-1:0]  seg_eff;
	logic [RttW-1:0]  m_eff;
	logic [ByteW-1:0] seq_gap;
	logic             div_busy;
	logic [ByteW-1:0] dp_window;
	logic [ByteW-1:0] thr_less;
	logic [ByteW-1:0] thr_lo;
	logic [ByteW-1:0] thr_floor;
	logic [ByteW-1:0] thr_res;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !seq_busy;
	assign fin_ok = !out_valid_q || m_axis_tready;
	assign fire = (ctl.fin != FIN_NONE) && fin_ok;

	// Zero segment size and zero minimum RTT act as one
	assign seg_eff = (seg_q == '0) ? SegW'(1) : seg_q;
	assign m_eff = (least_q == '0) ? RttW'(1) : least_q;

	// Update only with a nonzero RTT once acked_seq reaches the round end
	assign seq_gap = acked_q - round_end_q;
	assign st.not_upd = !((mode_q == MODE_UPDATE) && (latest_q != '0) && !seq_gap[ByteW-1]);
	assign st.div_busy = div_busy;

	// Slow-start threshold: max(min(ssthresh, cwnd - seg), 2 * seg)
	assign thr_less = cwnd_q - ByteW'(seg_eff);
	assign thr_lo = (thresh_q < thr_less) ? thresh_q : thr_less;
	assign thr_floor = ByteW'({seg_eff, 1'b0});
	assign thr_res = (thr_lo > thr_floor) ? thr_lo : thr_floor;

	rpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.st     (st),
		.fin_ok (fin_ok),
		.ctl    (ctl),
		.busy   (seq_busy)
	);

	rpc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.inflight   (inflight_q),
		.cwnd       (cwnd_q),
		.rtt        (latest_q),
		.min_rtt    (m_eff),
		.seg        (seg_eff),
		.div_busy   (div_busy),
		.new_window (dp_window)
	);

	// Capture the input transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q     <= mode_t'(s_axis_tuser);
			sample_q   <= s_axis_tdata[23:0];
			acked_q    <= s_axis_tdata[55:24];
			next_q     <= s_axis_tdata[87:56];
			inflight_q <= s_axis_tdata[119:88];
			cwnd_q     <= s_axis_tdata[151:120];
			latest_q   <= s_axis_tdata[175:152];
			thresh_q   <= s_axis_tdata[207:176];
		end
	end

	// Configuration, controller state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SegReset;
			least_q <= '1;
			round_end_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seg_q <= cfg_wr_data;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				if (ctl.fin == FIN_UPD) begin
					round_end_q <= next_q;
				end else if ((mode_q == MODE_RTT) && (sample_q != '0) &&
					(sample_q < least_q)) begin
					least_q <= sample_q;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			if (ctl.fin == FIN_UPD) begin
				out_changed_q <= 1'b1;
				out_window_q <= dp_window;
				out_thresh_q <= '0;
			end else begin
				out_changed_q <= 1'b0;
				out_window_q <= '0;
				out_thresh_q <= (mode_q == MODE_THRESH) ? thr_res : '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_changed_q;
	assign m_axis_tdata = {out_thresh_q, out_window_q};

	// A transfer always starts the microprogram
	`RPC_ASSERT_NEXT(a_accept_starts, in_fire, seq_busy)
	// The divider never runs while the sequencer is idle
	`RPC_ASSERT_IMPL(a_idle_div, !seq_busy, !div_busy)
	// The minimum RTT never drops to zero
	`RPC_ASSERT_ALWAYS(a_min_rtt_nonzero, least_q != '0)
	// A delivered update moves the round end to the captured next sequence
	`RPC_ASSERT_NEXT(a_round_advance, fire && (ctl.fin == FIN_UPD), round_end_q == $past(next_q))

endmodule
